// File: src/fif_pkg.sv
// Shared types, constants and helper functions of the five-tap FIR/IIR filter.
`default_nettype none

package fif_pkg;

    localparam int MAX_TAPS_DEF = 5;
    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 40;
    localparam int MUL_B_W      = 20;
    localparam int PROD_W       = SAMPLE_W + MUL_B_W;
    localparam int DIV_STEPS    = 16;
    localparam int DCNT_W       = $clog2(DIV_STEPS);
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;

    typedef enum logic [2:0] {
        REG_FILTER_MODE = 3'd0,
        REG_TAP_COUNT   = 3'd1,
        REG_NUM_LO      = 3'd2,
        REG_DEN_LO      = 3'd3,
        REG_COEFS_HIGH  = 3'd4
    } fif_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_NEW,
        ST_NMUL,
        ST_NACC,
        ST_PSUM,
        ST_PADD,
        ST_PMUL,
        ST_PSET,
        ST_PDIV,
        ST_PFIN,
        ST_FILL,
        ST_DONE
    } fif_state_t;

    typedef struct packed {
        logic        filter_mode;
        logic [2:0]  tap_count;
        logic [63:0] num_lo;
        logic [63:0] den_lo;
        logic [31:0] coefs_high;
    } fif_cfg_t;

    typedef struct packed {
        logic                       clip;
        logic signed [SAMPLE_W-1:0] val;
    } fif_sat_t;

    function automatic logic signed [15:0] num_coef(fif_cfg_t c, logic [2:0] i);
        case (i)
            3'd0:    return c.num_lo[15:0];
            3'd1:    return c.num_lo[31:16];
            3'd2:    return c.num_lo[47:32];
            3'd3:    return c.num_lo[63:48];
            default: return c.coefs_high[15:0];
        endcase
    endfunction

    function automatic logic signed [15:0] den_coef(fif_cfg_t c, logic [2:0] i);
        case (i)
            3'd0:    return c.den_lo[15:0];
            3'd1:    return c.den_lo[31:16];
            3'd2:    return c.den_lo[47:32];
            3'd3:    return c.den_lo[63:48];
            default: return c.coefs_high[31:16];
        endcase
    endfunction

    // Q.28 to Q1.15 with rounding to nearest, ties upward, then saturation.
    function automatic fif_sat_t q28_to_q15(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  t;
        logic signed [ACC_W-14:0] q;
        fif_sat_t                 r;
        t = v + ACC_W'(4096);
        q = t[ACC_W-1:13];
        r.clip = 1'b0;
        if (q > 32767) begin
            r.val  = 16'sh7FFF;
            r.clip = 1'b1;
        end else if (q < -32768) begin
            r.val  = 16'sh8000;
            r.clip = 1'b1;
        end else begin
            r.val = q[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/fif_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module fif_mul
    import fif_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       mul_en,
    input  wire logic signed [SAMPLE_W-1:0] op_a,
    input  wire logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]        prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: src/fif_cfg.sv
// Configuration register file behind an APB-style port.
`default_nettype none

module fif_cfg
    import fif_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output fif_cfg_t                   cfg
);

    fif_cfg_t cfg_reg;
    fif_cfg_t cfg_next;
    logic     wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[5:3])
                REG_FILTER_MODE: cfg_next.filter_mode = pwdata[0];
                REG_TAP_COUNT:   cfg_next.tap_count   = pwdata[2:0];
                REG_NUM_LO:      cfg_next.num_lo      = pwdata;
                REG_DEN_LO:      cfg_next.den_lo      = pwdata;
                REG_COEFS_HIGH:  cfg_next.coefs_high  = pwdata[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_mode <= 1'b0;
            cfg_reg.tap_count   <= 3'd5;
            cfg_reg.num_lo      <= '0;
            cfg_reg.den_lo      <= '0;
            cfg_reg.coefs_high  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_FILTER_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.filter_mode};
            REG_TAP_COUNT:   prdata = {{(APB_DATA_W-3){1'b0}}, cfg_reg.tap_count};
            REG_NUM_LO:      prdata = cfg_reg.num_lo;
            REG_DEN_LO:      prdata = cfg_reg.den_lo;
            REG_COEFS_HIGH:  prdata = {{(APB_DATA_W-32){1'b0}}, cfg_reg.coefs_high};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/fif_core.sv
// Sequencer, accumulators, divider and delay line of the filter.
`default_nettype none

module fif_core
    import fif_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fif_cfg_t            cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,
    output logic                     m_tuser
);

    localparam int TAP_W = $clog2(MAX_TAPS + 1);
    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    fif_state_t state_reg, state_next;

    logic [TAP_W-1:0]            n_reg, n_next, n_now;
    logic [IDX_W-1:0]            t_reg, t_next, rd_idx;
    logic                        half_reg, half_next;
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic                        pre_reg, pre_next;
    logic signed [ACC_W-1:0]     sn_reg, sn_next;
    logic signed [ACC_W-1:0]     sd_reg, sd_next;
    logic                        pend_reg, pend_next;
    logic                        pend_den_reg, pend_den_next;
    logic signed [SAMPLE_W-1:0]  newest_reg, newest_next;
    logic                        clip_reg, clip_next;
    logic [PROD_W+1:0]           rem_reg, rem_next;
    logic [PROD_W-1:0]           dsh_reg, dsh_next;
    logic [DIV_STEPS-1:0]        q_reg, q_next;
    logic [DCNT_W-1:0]           dcnt_reg, dcnt_next;
    logic                        neg_reg, neg_next;
    logic                        big_reg, big_next;
    logic                        m_valid_reg, m_valid_next;
    logic [15:0]                 m_data_reg, m_data_next;
    logic                        m_user_reg, m_user_next;
    logic signed [SAMPLE_W-1:0]  delay_reg [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]  delay_next [MAX_TAPS];

    logic                        mul_en;
    logic signed [SAMPLE_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0]   op_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     fb_val;
    logic [PROD_W-1:0]           ap;
    logic [ACC_W-1:0]            an_full;
    logic [MUL_B_W-1:0]          an;
    logic [MUL_B_W:0]            div2;
    logic [PROD_W+1:0]           dividend;
    logic                        big_now;
    logic                        last_tap;
    logic [2:0]                  cidx;
    logic [2:0]                  nidx;
    logic [SAMPLE_W:0]           neg_q;
    logic signed [15:0]          cn, cd, cl;
    fif_sat_t                    fb_sat, y_sat;

    fif_mul u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod   (prod)
    );

    always_comb begin
        if (cfg.tap_count == 3'd0) begin
            n_now = TAP_W'(1);
        end else if (cfg.tap_count > 3'(MAX_TAPS)) begin
            n_now = TAP_W'(MAX_TAPS);
        end else begin
            n_now = TAP_W'(cfg.tap_count);
        end
    end

    assign rd_idx   = t_reg + IDX_W'(1);
    assign cidx     = 3'(t_reg);
    assign nidx     = 3'(n_reg - TAP_W'(1));
    assign cn       = num_coef(cfg, cidx);
    assign cd       = den_coef(cfg, cidx);
    assign cl       = num_coef(cfg, nidx);
    assign last_tap = (TAP_W'(t_reg) + TAP_W'(2)) == n_reg;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign fb_val   = {{(ACC_W-SAMPLE_W-13){x_reg[SAMPLE_W-1]}}, x_reg, 13'b0} - sd_reg;
    assign fb_sat   = q28_to_q15(fb_val);
    assign y_sat    = q28_to_q15(sn_reg);
    assign ap       = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign an_full  = sn_reg[ACC_W-1] ? ACC_W'(-sn_reg) : ACC_W'(sn_reg);
    assign an       = an_full[MUL_B_W-1:0];
    assign div2     = {an, 1'b0};
    assign dividend = {1'b0, ap, 1'b0} + (PROD_W+2)'(an);
    assign big_now  = dividend >= {1'b0, div2, 16'b0};
    assign neg_q    = -{1'b0, q_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        state_next = cfg.filter_mode ? ST_PSUM : ST_FILL;
                    end else begin
                        state_next = (n_now > TAP_W'(1)) ? ST_MAC : ST_NEW;
                    end
                end
            end
            ST_MAC: begin
                if (half_reg && last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_NEW;
            ST_NEW:   state_next = ST_NMUL;
            ST_NMUL:  state_next = ST_NACC;
            ST_NACC:  state_next = ST_DONE;
            ST_PSUM: begin
                if ((TAP_W'(t_reg) + TAP_W'(1)) == n_reg) begin
                    state_next = ST_PADD;
                end
            end
            ST_PADD: state_next = ST_PMUL;
            ST_PMUL: state_next = ST_PSET;
            ST_PSET: begin
                if (sn_reg == '0) begin
                    state_next = ST_FILL;
                end else if (big_now) begin
                    state_next = ST_PFIN;
                end else begin
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_PFIN;
                end
            end
            ST_PFIN: state_next = ST_FILL;
            ST_FILL: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        n_next        = n_reg;
        t_next        = t_reg;
        half_next     = half_reg;
        x_next        = x_reg;
        pre_next      = pre_reg;
        sn_next       = sn_reg;
        sd_next       = sd_reg;
        pend_next     = pend_reg;
        pend_den_next = pend_den_reg;
        newest_next   = newest_reg;
        clip_next     = clip_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        dcnt_next     = dcnt_reg;
        neg_next      = neg_reg;
        big_next      = big_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        delay_next    = delay_reg;
        mul_en        = 1'b0;
        op_a          = x_reg;
        op_b          = '0;

        if ((state_reg == ST_MAC || state_reg == ST_DRAIN || state_reg == ST_NACC)
                && pend_reg) begin
            if (pend_den_reg) begin
                sd_next = sd_reg + prod_ext;
            end else begin
                sn_next = sn_reg + prod_ext;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next      = s_tdata;
                    pre_next    = s_tuser;
                    n_next      = n_now;
                    t_next      = '0;
                    half_next   = 1'b0;
                    sn_next     = '0;
                    sd_next     = '0;
                    clip_next   = 1'b0;
                    pend_next   = 1'b0;
                    newest_next = s_tdata;
                end
            end
            ST_MAC: begin
                mul_en        = 1'b1;
                op_a          = delay_reg[rd_idx];
                op_b          = half_reg ? {{4{cd[15]}}, cd} : {{4{cn[15]}}, cn};
                pend_next     = 1'b1;
                pend_den_next = half_reg;
                if (half_reg) begin
                    half_next = 1'b0;
                    t_next    = t_reg + IDX_W'(1);
                end else begin
                    half_next = 1'b1;
                end
            end
            ST_DRAIN: begin
                pend_next = 1'b0;
            end
            ST_NEW: begin
                if (cfg.filter_mode) begin
                    newest_next = fb_sat.val;
                    clip_next   = clip_reg | fb_sat.clip;
                end else begin
                    newest_next = x_reg;
                end
            end
            ST_NMUL: begin
                mul_en        = 1'b1;
                op_a          = newest_reg;
                op_b          = {{4{cl[15]}}, cl};
                pend_next     = 1'b1;
                pend_den_next = 1'b0;
                for (int i = 0; i < MAX_TAPS; i++) begin
                    if (i < MAX_TAPS - 1) begin
                        if (TAP_W'(i + 1) < n_reg) begin
                            delay_next[i] = delay_reg[i + 1];
                        end
                    end
                    if (TAP_W'(i + 1) == n_reg) begin
                        delay_next[i] = newest_reg;
                    end
                end
            end
            ST_NACC: begin
                pend_next = 1'b0;
            end
            ST_PSUM: begin
                sn_next = sn_reg + {{(ACC_W-16){cn[15]}}, cn};
                sd_next = sd_reg + {{(ACC_W-16){cd[15]}}, cd};
                t_next  = t_reg + IDX_W'(1);
            end
            ST_PADD: begin
                sd_next = sd_reg + sn_reg;
            end
            ST_PMUL: begin
                mul_en = 1'b1;
                op_a   = x_reg;
                op_b   = sd_reg[MUL_B_W-1:0];
            end
            ST_PSET: begin
                if (sn_reg == '0) begin
                    clip_next   = 1'b1;
                    newest_next = x_reg;
                end else begin
                    rem_next  = dividend;
                    dsh_next  = {div2, 15'b0};
                    q_next    = '0;
                    dcnt_next = '0;
                    neg_next  = prod[PROD_W-1] ^ sn_reg[ACC_W-1];
                    big_next  = big_now;
                end
            end
            ST_PDIV: begin
                if (rem_reg >= {2'b00, dsh_reg}) begin
                    rem_next = rem_reg - {2'b00, dsh_reg};
                    q_next   = {q_reg[DIV_STEPS-2:0], 1'b1};
                end else begin
                    q_next   = {q_reg[DIV_STEPS-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            ST_PFIN: begin
                if (big_reg) begin
                    newest_next = neg_reg ? 16'sh8000 : 16'sh7FFF;
                    clip_next   = 1'b1;
                end else if (neg_reg) begin
                    if (q_reg > 16'd32768) begin
                        newest_next = 16'sh8000;
                        clip_next   = 1'b1;
                    end else begin
                        newest_next = neg_q[15:0];
                    end
                end else if (q_reg > 16'd32767) begin
                    newest_next = 16'sh7FFF;
                    clip_next   = 1'b1;
                end else begin
                    newest_next = q_reg;
                end
            end
            ST_FILL: begin
                for (int i = 0; i < MAX_TAPS; i++) begin
                    if (TAP_W'(i) < n_reg) begin
                        delay_next[i] = newest_reg;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pre_reg ? 16'd0 : y_sat.val;
                    m_user_next  = pre_reg ? clip_reg : (clip_reg | y_sat.clip);
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                delay_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            delay_reg   <= delay_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        t_reg        <= t_next;
        half_reg     <= half_next;
        x_reg        <= x_next;
        pre_reg      <= pre_next;
        sn_reg       <= sn_next;
        sd_reg       <= sd_next;
        pend_den_reg <= pend_den_next;
        newest_reg   <= newest_next;
        clip_reg     <= clip_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        dcnt_reg     <= dcnt_next;
        neg_reg      <= neg_next;
        big_reg      <= big_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

endmodule

`default_nettype wire

// File: src/fir_iir_filter_five_tap_unit.sv
// Top level of the five-tap FIR/IIR filter: register port, sequencer core and ports.
//
// One word goes in and one word comes out per item. A sample word (tuser 0)
// runs through the taps in use on the single shared 16 x 20 bit multiplier,
// which forms one numerator and one denominator product per tap and only a
// numerator product for the newest value. A preload word (tuser 1) fills the
// delay line directly in FIR mode; in IIR mode it first sums the coefficients
// and scales the value in the 16-step shift-subtract divider. A zero numerator
// sum skips the divider and its final step, and an overflowing quotient skips
// the divider. The input is not ready while an item is in work, and
// a finished result waits in the output register while the next word is taken.
`default_nettype none

module fir_iir_filter_five_tap_unit
    import fif_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // [15:0] sample_in
    input  wire logic                  s_tuser,  // [0] mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,  // [15:0] filtered_out
    output logic                       m_tuser   // [0] clipped
);

    fif_cfg_t cfg;

    fif_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fif_core #(
        .MAX_TAPS (MAX_TAPS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: src/fif_checker.sv
// Port-level checker of the filter and its bind to the top level.
`default_nettype none

module fif_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input ready again too soon after a word");

    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result appeared while an item is still in work");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port stalled");

endmodule

bind fir_iir_filter_five_tap_unit fif_checker u_fif_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/fir_iir_filter_five_tap_checker.sv
// Checker for the five-tap FIR/IIR filter: follows register writes, predicts and compares results.
`timescale 1ns / 100ps

module fir_iir_filter_five_tap_checker
    import fif_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tuser,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    words_in,
    output int                    words_out,
    output int                    clipped_words
);

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
    } filter_out_t;

    logic               iir_mode;
    logic [2:0]         tap_setting;
    logic [63:0]        num_low;
    logic [63:0]        den_low;
    logic [31:0]        coef_high;
    logic signed [15:0] delay_taps [MAX_TAPS_DEF];
    filter_out_t        predicted_outputs [$];
    int                 errors;
    int                 n_in;
    int                 n_out;
    int                 n_clip;

    function automatic longint numer_coef(int i);
        if (i < 4)
            return longint'($signed(num_low[16*i +: 16]));
        return longint'($signed(coef_high[15:0]));
    endfunction

    function automatic longint denom_coef(int i);
        if (i < 4)
            return longint'($signed(den_low[16*i +: 16]));
        return longint'($signed(coef_high[31:16]));
    endfunction

    function automatic filter_out_t saturate16(longint v);
        filter_out_t r;
        r.clipped = (v > 32767) || (v < -32768);
        if (v > 32767)
            r.filtered = 16'sh7FFF;
        else if (v < -32768)
            r.filtered = 16'sh8000;
        else
            r.filtered = v[15:0];
        return r;
    endfunction

    // Q.28 back to Q1.15: the arithmetic shift floors, so adding half first rounds ties up.
    function automatic filter_out_t narrow_q28(longint acc);
        return saturate16((acc + 64'sd4096) >>> 13);
    endfunction

    function automatic filter_out_t filter_step(logic preload, logic signed [15:0] x);
        int          n;
        int          i;
        longint      num_acc;
        longint      den_acc;
        longint      prod;
        longint      mag_p;
        longint      mag_n;
        longint      quot;
        logic        neg;
        logic [15:0] fill;
        filter_out_t r;
        filter_out_t s;
        if (tap_setting == 3'd0)
            n = 1;
        else if (tap_setting > MAX_TAPS_DEF)
            n = MAX_TAPS_DEF;
        else
            n = tap_setting;
        r.filtered = '0;
        r.clipped  = 1'b0;
        num_acc    = 0;
        den_acc    = 0;
        if (preload) begin
            fill = x;
            if (iir_mode) begin
                for (i = 0; i < n; i++) begin
                    num_acc += numer_coef(i);
                    den_acc += denom_coef(i);
                end
                if (num_acc == 0) begin
                    r.clipped = 1'b1;
                end else begin
                    prod  = longint'(x) * (num_acc + den_acc);
                    neg   = (prod < 0) != (num_acc < 0);
                    mag_p = (prod < 0) ? -prod : prod;
                    mag_n = (num_acc < 0) ? -num_acc : num_acc;
                    quot  = (2 * mag_p + mag_n) / (2 * mag_n);
                    s     = saturate16(neg ? -quot : quot);
                    fill      = s.filtered;
                    r.clipped = s.clipped;
                end
            end
            for (i = 0; i < n; i++)
                delay_taps[i] = fill;
        end else begin
            for (i = 0; i + 1 < n; i++) begin
                delay_taps[i] = delay_taps[i+1];
                num_acc += longint'(delay_taps[i]) * numer_coef(i);
                den_acc += longint'(delay_taps[i]) * denom_coef(i);
            end
            if (iir_mode) begin
                s = narrow_q28(longint'(x) * 8192 - den_acc);
                delay_taps[n-1] = s.filtered;
                r.clipped = s.clipped;
            end else begin
                delay_taps[n-1] = x;
            end
            num_acc += longint'(delay_taps[n-1]) * numer_coef(n - 1);
            s = narrow_q28(num_acc);
            r.filtered = s.filtered;
            r.clipped  = r.clipped | s.clipped;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        filter_out_t want;
        int          i;
        if (!aresetn) begin
            iir_mode    = 1'b0;
            tap_setting = 3'd5;
            num_low     = '0;
            den_low     = '0;
            coef_high   = '0;
            for (i = 0; i < MAX_TAPS_DEF; i++)
                delay_taps[i] = '0;
            predicted_outputs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (fif_reg_idx_t'(paddr[APB_ADDR_W-1:3]))
                    REG_FILTER_MODE: iir_mode    = pwdata[0];
                    REG_TAP_COUNT:   tap_setting = pwdata[2:0];
                    REG_NUM_LO:      num_low     = pwdata;
                    REG_DEN_LO:      den_low     = pwdata;
                    REG_COEFS_HIGH:  coef_high   = pwdata[31:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                if (m_tuser)
                    n_clip++;
                if (predicted_outputs.size() == 0) begin
                    errors++;
                    $error("Unexpected result word: filtered_out %0d, clipped %0b",
                           $signed(m_tdata), m_tuser);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (m_tdata !== want.filtered) begin
                        errors++;
                        $error("filtered_out mismatch: expected %0d, got %0d",
                               $signed(want.filtered), $signed(m_tdata));
                    end
                    if (m_tuser !== want.clipped) begin
                        errors++;
                        $error("clipped mismatch: expected %0b, got %0b",
                               want.clipped, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_in++;
                predicted_outputs.push_back(filter_step(s_tuser, s_tdata));
            end
        end
        mismatch_count <= errors;
        pending_count  <= predicted_outputs.size();
        words_in       <= n_in;
        words_out      <= n_out;
        clipped_words  <= n_clip;
    end

    initial begin
        errors         = 0;
        n_in           = 0;
        n_out          = 0;
        n_clip         = 0;
        mismatch_count = 0;
        pending_count  = 0;
        words_in       = 0;
        words_out      = 0;
        clipped_words  = 0;
    end

endmodule

// File: bench/fir_iir_filter_five_tap_unit_tb.sv
// Testbench top for the five-tap FIR/IIR filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module fir_iir_filter_five_tap_unit_tb;
    import fif_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_PHASE = 178;

    typedef enum int {
        COEF_SMALL,
        COEF_FULL,
        COEF_BALANCED,
        COEF_MID
    } coef_style_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;

    int mismatch_count;
    int pending_count;
    int words_in;
    int words_out;
    int clipped_words;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int setting_count  = 0;

    int          tap_plan   [RANDOM_PHASES] = '{5, 1, 7, 4, 0, 2, 3, 6};
    int          mode_plan  [RANDOM_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 1};
    coef_style_t style_plan [RANDOM_PHASES] = '{COEF_SMALL, COEF_SMALL, COEF_FULL,
                                                COEF_BALANCED, COEF_MID, COEF_FULL,
                                                COEF_SMALL, COEF_BALANCED};
    int          send_plan  [4] = '{0, 55, 0, 35};
    int          recv_plan  [4] = '{0, 0, 55, 35};

    fir_iir_filter_five_tap_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fir_iir_filter_five_tap_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .words_in       (words_in),
        .words_out      (words_out),
        .clipped_words  (clipped_words)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (aresetn)
            m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(fif_reg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain(int settle);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apply_setting(logic iir, logic [2:0] taps, logic [63:0] num,
                                 logic [63:0] den, logic [31:0] high);
        drain(SETTLE_CYCLES);
        write_reg(REG_FILTER_MODE, {63'd0, iir});
        write_reg(REG_TAP_COUNT, {61'd0, taps});
        write_reg(REG_NUM_LO, num);
        write_reg(REG_DEN_LO, den);
        write_reg(REG_COEFS_HIGH, {32'd0, high});
        setting_count++;
    endtask

    task automatic send_word(logic preload, logic [15:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tuser  = $urandom;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = preload;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] rand_coef(int span);
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic pick_coefs(input coef_style_t style, output logic [63:0] num,
                              output logic [63:0] den, output logic [31:0] high);
        int nspan;
        int dspan;
        int k;
        nspan = (style == COEF_MID) ? 16'h2000 : 16'h0800;
        dspan = (style == COEF_MID) ? 16'h2000 : 16'h0400;
        for (k = 0; k < 4; k++) begin
            num[16*k +: 16] = rand_coef(nspan);
            den[16*k +: 16] = rand_coef(dspan);
        end
        high = {rand_coef(dspan), rand_coef(nspan)};
        if (style == COEF_FULL) begin
            num  = {$urandom, $urandom};
            den  = {$urandom, $urandom};
            high = $urandom;
        end
        // Pairs that cancel leave a zero numerator sum for two, four or five taps.
        if (style == COEF_BALANCED) begin
            num[31:16]  = -num[15:0];
            num[63:48]  = -num[47:32];
            high[15:0]  = '0;
        end
    endtask

    task automatic send_random_word();
        logic [15:0] value;
        int          pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(4))
                0:       value = 16'h7FFF;
                1:       value = 16'h8000;
                2:       value = 16'h0000;
                3:       value = 16'h0001;
                default: value = 16'hFFFF;
            endcase
        end else if (pick < 4) begin
            value = rand_coef(16'h0400);
        end else begin
            value = $urandom;
        end
        send_word($urandom_range(9) == 0, value);
    endtask

    initial begin : stimulus
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] high;
        int          phase;
        int          k;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: FIR over five taps with all coefficients zero.
        send_word(1'b0, 16'h7FFF);
        send_word(1'b1, 16'h8000);

        apply_setting(1'b0, 3'd5, {16'h2000, 16'h2000, 16'h7FFF, 16'h8000}, 64'd0,
                      {16'h8000, 16'h2000});
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'h0001);
        send_word(1'b1, 16'h1234);

        // Tap count above the maximum, preload scaling and feedback that both saturate.
        apply_setting(1'b1, 3'd7, {4{16'h2000}}, {4{16'h7FFF}}, {16'h7FFF, 16'h2000});
        send_word(1'b1, 16'h4000);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);

        // Tap count of zero with a zero numerator sum on preload.
        apply_setting(1'b1, 3'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_0000);
        send_word(1'b1, 16'h8000);
        send_word(1'b0, 16'h7FFF);

        // Preload scaling that lands exactly halfway between two values.
        apply_setting(1'b1, 3'd2, 64'h0000_0000_0001_0001, 64'h0000_0000_0000_0001, 32'd0);
        send_word(1'b1, 16'h0001);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b0, 16'h8000);

        // Output rounding ties on a single tap.
        apply_setting(1'b0, 3'd1, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                      32'hFFFF_FFFF);
        send_word(1'b0, 16'h1000);
        send_word(1'b0, 16'hF000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h8000);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_coefs(style_plan[phase], num, den, high);
            apply_setting(mode_plan[phase][0], tap_plan[phase][2:0], num, den, high);
            send_idle_pct  = send_plan[phase % 4];
            recv_stall_pct = recv_plan[phase % 4];
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if (k == WORDS_PER_PHASE / 2)
                    drain(0);
                send_random_word();
            end
        end

        drain(SETTLE_CYCLES);
        $display("Sent %0d words and checked %0d results, %0d of them clipped,",
                 words_in, words_out, clipped_words);
        $display("across %0d register settings in FIR and IIR mode.", setting_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
src/fif_pkg.sv
src/fif_mul.sv
src/fif_cfg.sv
src/fif_core.sv
src/fir_iir_filter_five_tap_unit.sv
src/fif_checker.sv
bench/fir_iir_filter_five_tap_checker.sv
bench/fir_iir_filter_five_tap_unit_tb.sv
